@@ rtl/core/fvtng_pkg.sv @@
// Shared types, constants and the level table of the four-voice tone and noise generator.
// No dependencies; every other file of the block imports this package.
package fvtng_pkg;

   // Fixed geometry
   localparam int VOICE_COUNT         = 4;
   localparam int TONE_COUNT          = 3;
   localparam int NOISE_VOICE         = 3;
   localparam int SHIFT_WIDTH_DEFAULT = 17;
   localparam int CFG_WIDTH           = 17;
   localparam int CNT_WIDTH           = 11;
   localparam int LEVEL_WIDTH         = 16;
   localparam int MIX_WIDTH           = 18;
   localparam int CSR_ADDR_WIDTH      = 4;
   localparam int CSR_DATA_WIDTH      = 32;

   // Register indexes (byte address 4*index)
   localparam logic [1:0] REG_WHITE_TAPS    = 2'd0;
   localparam logic [1:0] REG_PERIODIC_TAPS = 2'd1;
   localparam logic [1:0] REG_NOISE_SEED    = 2'd2;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] WHITE_TAPS_RESET    = 17'h12000;
   localparam logic [CFG_WIDTH-1:0] PERIODIC_TAPS_RESET = 17'h10000;
   localparam logic [CFG_WIDTH-1:0] NOISE_SEED_RESET    = 17'h10000;

   // Item operations
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Noise rate codes (low two bits of the noise mode)
   localparam logic [1:0] NOISE_RATE_16    = 2'd0;
   localparam logic [1:0] NOISE_RATE_32    = 2'd1;
   localparam logic [1:0] NOISE_RATE_64    = 2'd2;
   localparam logic [1:0] NOISE_RATE_TONE2 = 2'd3;

   // Reload constants
   localparam logic [CNT_WIDTH-1:0] RELOAD_ZERO_PERIOD = 11'h400;
   localparam logic [CNT_WIDTH-1:0] RELOAD_RATE_16     = 11'h010;
   localparam logic [CNT_WIDTH-1:0] RELOAD_RATE_32     = 11'h020;
   localparam logic [CNT_WIDTH-1:0] RELOAD_RATE_64     = 11'h040;

   localparam logic [3:0] ATTEN_SILENT = 4'hF;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [VOICE_COUNT-1:0] voice_high;
      logic [MIX_WIDTH-1:0]   mix_level;
   } rsp_payload_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] white_taps;
      logic [CFG_WIDTH-1:0] periodic_taps;
      logic [CFG_WIDTH-1:0] noise_seed;
   } cfg_type;

   // 2 dB per step, Q1.15, step 15 is silence
   function automatic logic [LEVEL_WIDTH-1:0] level_q15(input logic [3:0] atten);
      logic [LEVEL_WIDTH-1:0] lvl;
      case (atten)
         4'd0:    lvl = 16'd32768;
         4'd1:    lvl = 16'd26029;
         4'd2:    lvl = 16'd20675;
         4'd3:    lvl = 16'd16423;
         4'd4:    lvl = 16'd13045;
         4'd5:    lvl = 16'd10362;
         4'd6:    lvl = 16'd8231;
         4'd7:    lvl = 16'd6538;
         4'd8:    lvl = 16'd5193;
         4'd9:    lvl = 16'd4125;
         4'd10:   lvl = 16'd3277;
         4'd11:   lvl = 16'd2603;
         4'd12:   lvl = 16'd2068;
         4'd13:   lvl = 16'd1642;
         4'd14:   lvl = 16'd1305;
         default: lvl = 16'd0;
      endcase
      return lvl;
   endfunction

endpackage

@@ rtl/core/fvtng_regs.sv @@
// Configuration registers of the tone and noise generator behind an APB-style port.
// Depends on fvtng_pkg for register indexes, widths and reset values.
module fvtng_regs
   import fvtng_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];

   // Decode the write transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_WHITE_TAPS:    cfg_in.white_taps    = csr_pwdata[CFG_WIDTH-1:0];
            REG_PERIODIC_TAPS: cfg_in.periodic_taps = csr_pwdata[CFG_WIDTH-1:0];
            REG_NOISE_SEED:    cfg_in.noise_seed    = csr_pwdata[CFG_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.white_taps    <= WHITE_TAPS_RESET;
         cfg_ff.periodic_taps <= PERIODIC_TAPS_RESET;
         cfg_ff.noise_seed    <= NOISE_SEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_index)
         REG_WHITE_TAPS:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.white_taps);
         REG_PERIODIC_TAPS: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.periodic_taps);
         REG_NOISE_SEED:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.noise_seed);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/fvtng_gen.sv @@
// Voice state of the generator: register-write decode, counters, noise shift register, mix.
// Depends on fvtng_pkg; driven by the top level one item per fire cycle.
module fvtng_gen
   import fvtng_pkg::*;
#(
   parameter int SHIFT_WIDTH = SHIFT_WIDTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  req_payload_type item,
   input  cfg_type         cfg,
   output rsp_payload_type result
);

   logic [2:0]             sel_ff, sel_in;
   logic [3:0]             atten_ff [VOICE_COUNT];
   logic [3:0]             atten_in [VOICE_COUNT];
   logic [9:0]             period_ff [TONE_COUNT];
   logic [9:0]             period_in [TONE_COUNT];
   logic [2:0]             mode_ff, mode_in;
   logic [CNT_WIDTH-1:0]   cnt_ff [VOICE_COUNT];
   logic [CNT_WIDTH-1:0]   cnt_in [VOICE_COUNT];
   logic [VOICE_COUNT-1:0] out_ff, out_in;
   logic [SHIFT_WIDTH-1:0] shift_ff, shift_in;
   logic                   half_ff, half_in;

   logic [CNT_WIDTH-1:0]   tone_reload [TONE_COUNT];
   logic [CNT_WIDTH-1:0]   noise_reload;
   logic [SHIFT_WIDTH-1:0] taps;
   logic [MIX_WIDTH-1:0]   mix;

   // Reload values: a zero period counts as 0x400
   always_comb begin
      for (int i = 0; i < TONE_COUNT; i++) begin
         tone_reload[i] = (period_ff[i] == 10'd0) ? RELOAD_ZERO_PERIOD
                                                  : CNT_WIDTH'(period_ff[i]);
      end
      case (mode_ff[1:0])
         NOISE_RATE_16: noise_reload = RELOAD_RATE_16;
         NOISE_RATE_32: noise_reload = RELOAD_RATE_32;
         NOISE_RATE_64: noise_reload = RELOAD_RATE_64;
         default:       noise_reload = tone_reload[TONE_COUNT-1];
      endcase
      taps = mode_ff[2] ? cfg.white_taps[SHIFT_WIDTH-1:0]
                        : cfg.periodic_taps[SHIFT_WIDTH-1:0];
   end

   // Next state for one item
   always_comb begin
      logic [SHIFT_WIDTH-1:0] s;
      logic [1:0]             v;
      sel_in   = sel_ff;
      atten_in = atten_ff;
      period_in = period_ff;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      out_in   = out_ff;
      shift_in = shift_ff;
      half_in  = half_ff;
      s = shift_ff;
      v = 2'd0;
      if (fire) begin
         if (item.operation == OP_TICK) begin
            // Tone voices: count down, reload and toggle
            for (int i = 0; i < TONE_COUNT; i++) begin
               if (cnt_ff[i] > CNT_WIDTH'(1)) begin
                  cnt_in[i] = cnt_ff[i] - CNT_WIDTH'(1);
               end else begin
                  cnt_in[i] = tone_reload[i];
                  out_in[i] = ~out_ff[i];
               end
            end
            // Noise voice: shift on every second reload
            if (cnt_ff[NOISE_VOICE] > CNT_WIDTH'(1)) begin
               cnt_in[NOISE_VOICE] = cnt_ff[NOISE_VOICE] - CNT_WIDTH'(1);
            end else begin
               cnt_in[NOISE_VOICE] = noise_reload;
               half_in = ~half_ff;
               if (!half_ff) begin
                  if (s[0]) begin
                     s = s ^ taps;
                  end
                  s = s >> 1;
                  shift_in = s;
                  out_in[NOISE_VOICE] = s[0];
               end
            end
         end else begin
            if (item.data_byte[7]) begin
               sel_in = item.data_byte[6:4];
            end
            v = sel_in[2:1];
            if (sel_in[0]) begin
               atten_in[v] = item.data_byte[3:0];
            end else if (v == 2'(NOISE_VOICE)) begin
               // Mode write restarts the shift register from the seed
               mode_in  = item.data_byte[2:0];
               shift_in = cfg.noise_seed[SHIFT_WIDTH-1:0];
               out_in[NOISE_VOICE] = cfg.noise_seed[0];
            end else begin
               for (int i = 0; i < TONE_COUNT; i++) begin
                  if (v == 2'(i)) begin
                     if (item.data_byte[7]) begin
                        period_in[i][3:0] = item.data_byte[3:0];
                     end else begin
                        period_in[i][9:4] = item.data_byte[5:0];
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= '0;
         mode_ff  <= '0;
         out_ff   <= '0;
         half_ff  <= 1'b0;
         shift_ff <= NOISE_SEED_RESET[SHIFT_WIDTH-1:0];
         for (int i = 0; i < VOICE_COUNT; i++) begin
            atten_ff[i] <= ATTEN_SILENT;
            cnt_ff[i]   <= '0;
         end
         for (int i = 0; i < TONE_COUNT; i++) begin
            period_ff[i] <= '0;
         end
      end else begin
         sel_ff    <= sel_in;
         mode_ff   <= mode_in;
         out_ff    <= out_in;
         half_ff   <= half_in;
         shift_ff  <= shift_in;
         atten_ff  <= atten_in;
         cnt_ff    <= cnt_in;
         period_ff <= period_in;
      end
   end

   // Mix the levels of the voices that are high after this item
   always_comb begin
      mix = '0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
         if (out_in[i]) begin
            mix = mix + MIX_WIDTH'(level_q15(atten_in[i]));
         end
      end
      result.voice_high = out_in;
      result.mix_level  = mix;
   end

endmodule

@@ rtl/core/four_voice_tone_noise_generator.sv @@
// Four-voice tone and noise generator: usage notes.
// Request channel (req_valid, req_stall, req_data): each transfer carries one item, either a
//   register write byte (operation 0) or one generator step tick (operation 1).
// Result channel (rsp_valid, rsp_stall, rsp_data): exactly one result per item, in order,
//   holding the four voice output bits and the Q3.15 mix of the voices that are high.
// Path: a request is captured in the input register and its result in the result register,
//   which drives rsp_valid. Throughput: one item per cycle while rsp_stall is low; the
//   whole voice update and mix sit between the input register and the result register.
// Stall: while rsp_stall holds a result, one more item is taken into the input register;
//   after that req_stall rises until the result is taken.
// Configuration: APB-style port, white taps at 0x0, periodic taps at 0x4, noise seed at
//   0x8; write only while the block is idle. The seed takes effect at the next noise mode
//   write; reset loads the reset seed instead.
// Reset (synchronous): both channels empty, all voices silent (attenuation 15), periods,
//   mode and counters zero, noise shift register loaded with the reset seed.
// Depends on fvtng_pkg, fvtng_regs and fvtng_gen.
module four_voice_tone_noise_generator
   import fvtng_pkg::*;
#(
   parameter int SHIFT_WIDTH = SHIFT_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   logic            out_free, fire, req_accept;
   cfg_type         cfg;
   rsp_payload_type result;

   fvtng_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fvtng_gen #(
      .SHIFT_WIDTH (SHIFT_WIDTH)
   ) u_gen (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Flow control: advance when the result register is empty or being taken
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payloads until the next transfer
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("item left the input register without a result");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid && rsp_stall))
      else $error("request stalled while a stage was free");

   a_silent_mix: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.voice_high == '0) |-> (rsp_data.mix_level == '0))
      else $error("nonzero mix with all voices low");
`endif

endmodule
